FILE: hw/rtl/first_fit_heap_allocator_top_assert.svh
// Assertion macros for the heap allocator.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define FFHA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FFHA_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define FFHA_ASSERT(lbl, clk, rst_n, prop, msg)
`define FFHA_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

FILE: hw/rtl/ffha_pkg.sv
package ffha_pkg;

	localparam int HEAP_BYTES_DEF = 4096;

	localparam int REQ_W   = 16;
	localparam int BADDR_W = 12;
	localparam int ADDR_W  = 12;
	localparam int NEED_W  = 15;
	localparam int CMP_W   = 16;

	localparam int S_TDATA_W = 32;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 16;
	localparam int M_TUSER_W = 1;

	// 0xffff bytes expressed in words, rounded up: no run can reach it
	localparam logic [NEED_W-1:0] MERGE_ALL_NEED = 15'h4000;

	typedef enum logic [1:0] {
		MODE_ALLOC     = 2'd0,
		MODE_RELEASE   = 2'd1,
		MODE_MERGE_ALL = 2'd2,
		MODE_NOP       = 2'd3
	} mode_t;

endpackage

FILE: hw/rtl/first_fit_heap_allocator_top.sv
// First-fit heap allocator with boundary tags.
// Input stream: s_tuser carries the mode (allocate, release, merge all,
// no-op), s_tdata the request size and the block address to release. One
// result beat per input beat on the output stream: m_tdata holds the
// payload offset, m_tuser the granted flag.
// Headers live in a single-port-write, single-port-read memory of
// HEAP_BYTES/4 words; a small sequencer walks it.
// After accept, a no-op, a zero request and an ignored release go straight
// to ST_DONE; a release passes ST_R_WR, an allocate from the current free
// block ST_A_CHK, ST_A_FIT and ST_A_HDR. A walk visits header after
// header, end marker included; merge-all then passes ST_W_END, an allocate
// that finds a run ST_A_FIT and ST_A_HDR. s_tready is high again in the
// cycle the result appears. After reset the header memory is cleared, one
// word per cycle, over all HEAP_BYTES/4 words; s_tready stays low until done.
// A finished result waits in the output register while the next item is
// taken; when m_tready is low, the block holds its next result until the
// output register is free.
`include "first_fit_heap_allocator_top_assert.svh"

module first_fit_heap_allocator_top #(
	parameter int HEAP_BYTES = ffha_pkg::HEAP_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [15:0] request_bytes, [27:16] block_address
	input  logic [ffha_pkg::S_TDATA_W-1:0]  s_tdata,
	// [1:0] mode
	input  logic [ffha_pkg::S_TUSER_W-1:0]  s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [11:0] address
	output logic [ffha_pkg::M_TDATA_W-1:0]  m_tdata,
	// [0] granted
	output logic [ffha_pkg::M_TUSER_W-1:0]  m_tuser
);
	import ffha_pkg::*;

	localparam int HEAP_WORDS = HEAP_BYTES / 4;
	localparam int WORD_W = $clog2(HEAP_WORDS);
	localparam logic [WORD_W:0] HEAP_WORDS_X = (WORD_W+1)'(HEAP_WORDS);
	localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(HEAP_WORDS - 1);

	typedef struct packed {
		logic              used;
		logic [WORD_W-1:0] size;
	} hdr_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_A_CHK,
		ST_WALK,
		ST_W_END,
		ST_A_FIT,
		ST_A_HDR,
		ST_R_WR,
		ST_DONE
	} state_t;

	state_t state_q;

	hdr_t mem [HEAP_WORDS];
	hdr_t rd_q;
	logic              mem_we;
	logic [WORD_W-1:0] mem_wa;
	hdr_t              mem_wd;
	logic [WORD_W-1:0] mem_ra;

	logic [WORD_W-1:0] clr_q;
	logic [WORD_W-1:0] free_ptr_q;
	logic              free_valid_q;
	logic [WORD_W-1:0] pos_q;
	logic [WORD_W:0]   run_start_q;
	logic [WORD_W:0]   run_size_q;
	logic [NEED_W-1:0] need_q;
	logic [WORD_W-1:0] at_q;
	logic [WORD_W-1:0] fsize_q;
	logic [WORD_W-1:0] hdr_size_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic              res_granted_q;

	logic [REQ_W-1:0]   in_req;
	logic [BADDR_W-1:0] in_baddr;
	mode_t              in_mode;
	logic [NEED_W-1:0]  in_need;
	logic [BADDR_W-3:0] rel_w;
	logic               rel_ok;
	logic [WORD_W-1:0]  rel_word;
	logic               accept;

	logic [WORD_W:0]   next_w;
	logic              next_end;
	logic [CMP_W-1:0]  need_c;
	logic              run_hit;
	logic              run_start_ok;
	logic              too_small;
	logic [CMP_W-1:0]  at_need;
	logic              fits;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	assign in_req   = s_tdata[REQ_W-1:0];
	assign in_baddr = s_tdata[REQ_W +: BADDR_W];
	assign in_mode  = mode_t'(s_tuser[1:0]);
	assign in_need  = NEED_W'(({1'b0, in_req} + (REQ_W+1)'(7)) >> 2);
	assign rel_w    = in_baddr[BADDR_W-1:2] - (BADDR_W-2)'(1);
	assign rel_ok   = (in_baddr >= BADDR_W'(4)) && (in_baddr[1:0] == 2'b00) &&
		(CMP_W'(rel_w) < CMP_W'(HEAP_WORDS));
	assign rel_word = WORD_W'(rel_w);

	assign next_w       = {1'b0, pos_q} + {1'b0, rd_q.size};
	assign next_end     = next_w >= HEAP_WORDS_X;
	assign need_c       = CMP_W'(need_q);
	assign run_hit      = CMP_W'(run_size_q) >= need_c;
	assign run_start_ok = run_start_q < HEAP_WORDS_X;
	assign too_small    = need_c > CMP_W'(rd_q.size);
	assign at_need      = CMP_W'(at_q) + need_c;
	assign fits         = (CMP_W'(fsize_q) > need_c) && (at_need < CMP_W'(HEAP_WORDS));

	// header memory port control
	always_comb begin
		mem_we = 1'b0;
		mem_wa = at_q;
		mem_wd = '0;
		mem_ra = '0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				if (clr_q == '0) begin
					mem_wd.size = LAST_WORD;
				end
			end
			ST_IDLE: begin
				if (in_mode == MODE_RELEASE) begin
					mem_ra = rel_word;
				end else if (in_mode == MODE_ALLOC && free_valid_q) begin
					mem_ra = free_ptr_q;
				end
			end
			ST_WALK: begin
				mem_ra = next_w[WORD_W-1:0];
				if (rd_q.size != '0 && rd_q.used && run_size_q != '0) begin
					mem_we = 1'b1;
					mem_wa = run_start_q[WORD_W-1:0];
					mem_wd.size = run_size_q[WORD_W-1:0];
				end
			end
			ST_W_END: begin
				if (run_size_q != '0 && run_start_ok) begin
					mem_we = 1'b1;
					mem_wa = run_start_q[WORD_W-1:0];
					mem_wd.size = run_size_q[WORD_W-1:0];
				end
			end
			ST_A_FIT: begin
				if (fits) begin
					mem_we = 1'b1;
					mem_wa = at_need[WORD_W-1:0];
					mem_wd.size = fsize_q - WORD_W'(need_q);
				end
			end
			ST_A_HDR: begin
				mem_we = 1'b1;
				mem_wd.used = 1'b1;
				mem_wd.size = hdr_size_q;
			end
			ST_R_WR: begin
				mem_we = 1'b1;
				mem_wd.size = rd_q.size;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_q         <= '0;
			free_ptr_q    <= '0;
			free_valid_q  <= 1'b1;
			pos_q         <= '0;
			run_start_q   <= '0;
			run_size_q    <= '0;
			need_q        <= '0;
			at_q          <= '0;
			fsize_q       <= '0;
			hdr_size_q    <= '0;
			res_addr_q    <= '0;
			res_granted_q <= 1'b0;
			m_tvalid      <= 1'b0;
			m_tdata       <= '0;
			m_tuser       <= '0;
		end else begin
			if (m_tvalid && m_tready && state_q != ST_DONE) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + WORD_W'(1);
					if (clr_q == LAST_WORD) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						res_addr_q    <= '0;
						res_granted_q <= 1'b0;
						pos_q         <= '0;
						run_start_q   <= '0;
						run_size_q    <= '0;
						at_q          <= rel_word;
						unique case (in_mode)
							MODE_ALLOC: begin
								need_q <= in_need;
								if (in_req == '0) begin
									state_q <= ST_DONE;
								end else if (free_valid_q) begin
									state_q <= ST_A_CHK;
								end else begin
									state_q <= ST_WALK;
								end
							end
							MODE_RELEASE: begin
								state_q <= rel_ok ? ST_R_WR : ST_DONE;
							end
							MODE_MERGE_ALL: begin
								need_q  <= MERGE_ALL_NEED;
								state_q <= ST_WALK;
							end
							MODE_NOP: begin
								state_q <= ST_DONE;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_A_CHK: begin
					if (too_small) begin
						state_q <= ST_WALK;
					end else begin
						at_q    <= free_ptr_q;
						fsize_q <= rd_q.size;
						state_q <= ST_A_FIT;
					end
				end
				ST_WALK: begin
					if (rd_q.size == '0) begin
						state_q <= ST_W_END;
					end else if (rd_q.used && run_size_q != '0 && run_hit) begin
						at_q         <= run_start_q[WORD_W-1:0];
						fsize_q      <= run_size_q[WORD_W-1:0];
						free_ptr_q   <= run_start_q[WORD_W-1:0];
						free_valid_q <= 1'b1;
						state_q      <= ST_A_FIT;
					end else begin
						if (rd_q.used) begin
							run_size_q  <= '0;
							run_start_q <= next_w;
						end else begin
							run_size_q <= run_size_q + (WORD_W+1)'(rd_q.size);
						end
						pos_q <= next_w[WORD_W-1:0];
						if (next_end) begin
							state_q <= ST_W_END;
						end
					end
				end
				ST_W_END: begin
					if (run_size_q != '0 && run_start_ok && run_hit) begin
						at_q         <= run_start_q[WORD_W-1:0];
						fsize_q      <= run_size_q[WORD_W-1:0];
						free_ptr_q   <= run_start_q[WORD_W-1:0];
						free_valid_q <= 1'b1;
						state_q      <= ST_A_FIT;
					end else begin
						free_ptr_q   <= '0;
						free_valid_q <= 1'b0;
						state_q      <= ST_DONE;
					end
				end
				ST_A_FIT: begin
					if (fits) begin
						free_ptr_q <= at_need[WORD_W-1:0];
						hdr_size_q <= WORD_W'(need_q);
					end else begin
						free_ptr_q   <= '0;
						free_valid_q <= 1'b0;
						hdr_size_q   <= fsize_q;
					end
					state_q <= ST_A_HDR;
				end
				ST_A_HDR: begin
					res_addr_q    <= ADDR_W'(CMP_W'({at_q, 2'b00}) + CMP_W'(4));
					res_granted_q <= 1'b1;
					state_q       <= ST_DONE;
				end
				ST_R_WR: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tdata  <= M_TDATA_W'(res_addr_q);
						m_tuser  <= M_TUSER_W'(res_granted_q);
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`FFHA_ASSERT(a_busy_after_accept, clk, arst_n, accept |=> !s_tready, "ready after accept")
	`FFHA_ASSERT(a_out_from_done, clk, arst_n, $rose(m_tvalid) |-> $past(state_q == ST_DONE), "result outside done")
	`FFHA_ASSERT(a_fail_zero_addr, clk, arst_n, (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0), "failed result with address")
	`FFHA_ASSERT_NEVER(a_free_ptr_clear, clk, arst_n, !free_valid_q && free_ptr_q != '0, "stale free pointer")

endmodule
